@@ sv/cdq_pkg.sv @@
// shared types and constants for the circular deque
package cdq_pkg;

    localparam int CFG_W      = 5;
    localparam int CAP_RESET  = 16;
    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_status;

endpackage

@@ sv/cdq_if.sv @@
// operation and result channels of the circular deque
interface cdq_op_if #(
    parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEF
);
    logic                          valid;
    logic                          ready;
    cdq_pkg::t_kind                kind;
    logic signed [DATA_WIDTH-1:0]  push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface cdq_res_if #(
    parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEF
);
    logic                          valid;
    logic                          ready;
    cdq_pkg::t_status              status;
    logic signed [DATA_WIDTH-1:0]  popped_value;
    logic                          is_empty;
    logic                          is_full;

    modport source (output valid, output status, output popped_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input is_empty, input is_full, output ready);
endinterface

@@ sv/circular_deque_unit.sv @@
// circular deque top level: index control, ring store and result register
// a result is offered in the cycle after its operation transfers
// throughput: one operation per cycle while the result is taken; the ring store port is used at most once per op
// pops read the store and the registered read data feeds the result directly
// synchronous active-low reset: empty queue, head = tail = 0, capacity 16
// (clamped to DEPTH); store contents stay undefined until written
module circular_deque_unit #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    cdq_op_if.sink                    i_op,
    cdq_res_if.source                 o_res,
    input  logic                      i_cfg_we,
    input  logic [cdq_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int RESET_CAP = (cdq_pkg::CAP_RESET > DEPTH) ? DEPTH : cdq_pkg::CAP_RESET;

    // ring indices wrap at the last slot in use (capacity - 1)
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic             r_empty, n_empty;
    logic [IDX_W-1:0] r_cap_m1;

    // result stage
    logic             r_out_valid;
    cdq_pkg::t_status r_status, n_status;
    logic             r_pop_ok, n_pop_ok;
    logic             r_is_empty;
    logic             r_is_full, n_full;

    // store access
    logic                  w_accept;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic [IDX_W-1:0]      w_addr;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic                  w_full_now;

    // capacity decode for a configuration write
    logic [31:0]      w_cfg_ext;
    logic [31:0]      w_cap_eff;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] idx,
                                                input logic [IDX_W-1:0] last);
        logic [IDX_W-1:0] res;
        res = (idx == last) ? '0 : IDX_W'(idx + 1'b1);
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] f_prev(input logic [IDX_W-1:0] idx,
                                                input logic [IDX_W-1:0] last);
        logic [IDX_W-1:0] res;
        res = (idx == '0) ? last : IDX_W'(idx - 1'b1);
        return res;
    endfunction

    // a new op may transfer whenever the result slot is free or drains now
    assign i_op.ready = !r_out_valid || o_res.ready;
    assign w_accept   = i_op.valid && i_op.ready;

    assign w_full_now = !r_empty && (f_next(r_tail, r_cap_m1) == r_head);

    // zero capacity means one slot, anything above the store depth saturates
    assign w_cfg_ext = 32'(i_cfg_wdata);
    always_comb begin
        if (w_cfg_ext == 32'd0) begin
            w_cap_eff = 32'd1;
        end else if (w_cfg_ext > 32'(DEPTH)) begin
            w_cap_eff = 32'(DEPTH);
        end else begin
            w_cap_eff = w_cfg_ext;
        end
    end

    // next-state decode of the indices and the store access for this op
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_status = cdq_pkg::STAT_DONE;
        n_pop_ok = 1'b0;
        w_wr_en  = 1'b0;
        w_rd_en  = 1'b0;
        w_addr   = r_head;

        unique case (i_op.kind)
            cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_BACK: begin
                if (r_empty) begin
                    // first entry always lands in slot zero
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    w_wr_en = 1'b1;
                    w_addr  = '0;
                end else if (w_full_now) begin
                    n_status = cdq_pkg::STAT_OVERFLOW;
                end else if (i_op.kind == cdq_pkg::KIND_PUSH_FRONT) begin
                    n_head  = f_prev(r_head, r_cap_m1);
                    w_wr_en = 1'b1;
                    w_addr  = n_head;
                end else begin
                    n_tail  = f_next(r_tail, r_cap_m1);
                    w_wr_en = 1'b1;
                    w_addr  = n_tail;
                end
            end
            cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_BACK: begin
                if (r_empty) begin
                    n_status = cdq_pkg::STAT_UNDERFLOW;
                end else begin
                    n_pop_ok = 1'b1;
                    w_rd_en  = 1'b1;
                    w_addr   = (i_op.kind == cdq_pkg::KIND_POP_FRONT) ? r_head : r_tail;
                    if (r_head == r_tail) begin
                        // removing the last entry
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b1;
                    end else if (i_op.kind == cdq_pkg::KIND_POP_FRONT) begin
                        n_head = f_next(r_head, r_cap_m1);
                    end else begin
                        n_tail = f_prev(r_tail, r_cap_m1);
                    end
                end
            end
            default: begin
                n_status = cdq_pkg::STAT_DONE;
            end
        endcase

        n_full = !n_empty && (f_next(n_tail, r_cap_m1) == n_head);
    end

    // the store sees an access only for a transferred op, so a pop never
    // meets a write in the same cycle and needs no forwarding
    cdq_ring #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && w_wr_en),
        .i_rd_en   (w_accept && w_rd_en),
        .i_addr    (w_addr),
        .i_wr_data (i_op.push_value),
        .o_rd_data (w_rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_cap_m1    <= IDX_W'(RESET_CAP - 1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                // any capacity write also empties the queue
                r_cap_m1 <= IDX_W'(w_cap_eff - 32'd1);
                r_head   <= '0;
                r_tail   <= '0;
                r_empty  <= 1'b1;
            end else if (w_accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_empty <= n_empty;
            end

            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, held while the result stalls
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_pop_ok   <= n_pop_ok;
            r_is_empty <= n_empty;
            r_is_full  <= n_full;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_status;
    assign o_res.popped_value = r_pop_ok ? w_rd_data : '0;
    assign o_res.is_empty     = r_is_empty;
    assign o_res.is_full      = r_is_full;

endmodule

@@ sv/cdq_ring.sv @@
// ring store: single-port synchronous memory with registered read data
module cdq_ring #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEF,
    localparam int IDX_W     = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic                  i_rd_en,
    input  logic [IDX_W-1:0]      i_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
